// ===== design/bdpc_pkg.sv =====
// Shared types, constants and register codes for the button press classifier.
package bdpc_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int CFG_INDEX_WIDTH = 8;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  // register indexes on the configuration port
  localparam cfg_index_t REG_DEBOUNCE_TIME = cfg_index_t'(0);
  localparam cfg_index_t REG_LONG_PRESS_TIME = cfg_index_t'(1);
  localparam cfg_index_t REG_BOOT_WINDOW_TIME = cfg_index_t'(2);
  localparam cfg_index_t REG_RECOVERY_HOLD_TIME = cfg_index_t'(3);

  localparam time_t DEBOUNCE_TIME_RESET = time_t'(35);
  localparam time_t LONG_PRESS_TIME_RESET = time_t'(1200);
  localparam time_t BOOT_WINDOW_TIME_RESET = time_t'(30000);
  localparam time_t RECOVERY_HOLD_TIME_RESET = time_t'(10000);

  localparam logic LEVEL_PRESSED = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_SHORT    = 2'd1,
    EV_LONG     = 2'd2,
    EV_RECOVERY = 2'd3
  } press_event_t;

  typedef struct packed {
    time_t debounce_time;
    time_t long_press_time;
    time_t boot_window_time;
    time_t recovery_hold_time;
  } bdpc_cfg_t;

  typedef struct packed {
    logic  pin_level;
    time_t now_ms;
  } bdpc_sample_t;

endpackage

// ===== design/bdpc_in_if.sv =====
// Sample request channel: raw button level and millisecond timestamp.
interface bdpc_in_if
  import bdpc_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  pin_level;
  time_t now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink (input valid, input pin_level, input now_ms, output ready);
endinterface

// ===== design/bdpc_out_if.sv =====
// Result request channel: classified press event.
interface bdpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink (input valid, input press_event, output ready);
endinterface

// ===== design/bdpc_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface bdpc_cfg_if
  import bdpc_pkg::*;
();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  time_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bdpc_cfg_regs.sv =====
// Configuration register file for the thresholds and windows.
module bdpc_cfg_regs
  import bdpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bdpc_cfg_if.sink   cfg,
  output bdpc_cfg_t  cfg_regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.debounce_time <= DEBOUNCE_TIME_RESET;
      cfg_regs.long_press_time <= LONG_PRESS_TIME_RESET;
      cfg_regs.boot_window_time <= BOOT_WINDOW_TIME_RESET;
      cfg_regs.recovery_hold_time <= RECOVERY_HOLD_TIME_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_DEBOUNCE_TIME:      cfg_regs.debounce_time <= cfg.data;
        REG_LONG_PRESS_TIME:    cfg_regs.long_press_time <= cfg.data;
        REG_BOOT_WINDOW_TIME:   cfg_regs.boot_window_time <= cfg.data;
        REG_RECOVERY_HOLD_TIME: cfg_regs.recovery_hold_time <= cfg.data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

endmodule

// ===== design/bdpc_core.sv =====
// Debounce and press classification state with its single-pass update logic.
module bdpc_core
  import bdpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  bdpc_cfg_t    cfg_regs,
  input  logic         advance,
  input  bdpc_sample_t sample,
  output press_event_t press_event
);

  logic  stable_level, stable_level_next;
  logic  last_level;
  time_t change_time, change_time_next;
  time_t press_time, press_time_next;
  time_t window_start, window_start_next;
  logic  long_done, long_done_next;
  logic  boot_press, boot_press_next;
  logic  window_started;

  logic  level_changed;
  time_t since_change;
  logic  level_accepted;
  logic  press_edge;
  time_t held;

  always_comb begin
    window_start_next = window_started ? window_start : sample.now_ms;
    level_changed = (sample.pin_level != last_level);
    change_time_next = level_changed ? sample.now_ms : change_time;
    since_change = sample.now_ms - change_time_next;
    level_accepted = (since_change >= cfg_regs.debounce_time)
                     && (sample.pin_level != stable_level);
    press_edge = level_accepted && (sample.pin_level == LEVEL_PRESSED);

    stable_level_next = level_accepted ? sample.pin_level : stable_level;
    press_time_next = press_time;
    long_done_next = long_done;
    boot_press_next = boot_press;
    press_event = EV_NONE;
    held = sample.now_ms - press_time;

    if (press_edge) begin
      press_time_next = sample.now_ms;
      long_done_next = 1'b0;
      boot_press_next = (sample.now_ms - window_start_next) <= cfg_regs.boot_window_time;
      held = '0;
    end

    if (level_accepted && (sample.pin_level == LEVEL_RELEASED) && !long_done) begin
      // release ends the press; a boot press held past the long threshold counts long
      if (boot_press && (held >= cfg_regs.long_press_time)) begin
        long_done_next = 1'b1;
        press_event = EV_LONG;
      end else begin
        press_event = EV_SHORT;
      end
    end else if ((stable_level_next == LEVEL_PRESSED) && !long_done_next
                 && (held >= cfg_regs.long_press_time)) begin
      if (boot_press_next) begin
        if (held >= cfg_regs.recovery_hold_time) begin
          long_done_next = 1'b1;
          press_event = EV_RECOVERY;
        end
      end else begin
        long_done_next = 1'b1;
        press_event = EV_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= LEVEL_RELEASED;
      last_level <= LEVEL_RELEASED;
      change_time <= '0;
      press_time <= '0;
      window_start <= '0;
      long_done <= 1'b0;
      boot_press <= 1'b0;
      window_started <= 1'b0;
    end else if (advance) begin
      stable_level <= stable_level_next;
      last_level <= sample.pin_level;
      change_time <= change_time_next;
      press_time <= press_time_next;
      window_start <= window_start_next;
      long_done <= long_done_next;
      boot_press <= boot_press_next;
      window_started <= 1'b1;
    end
  end

endmodule

// ===== design/button_debounce_press_classifier.sv =====
// Top level: sample register, classifier core and result register.
//
//   channel  | modport | moves                          | accepted when
//   in_ch    | sink    | pin_level, now_ms              | in_ch.valid && in_ch.ready
//   out_ch   | source  | press_event                    | out_ch.valid && out_ch.ready
//   cfg      | sink    | index, data                    | cfg.valid && cfg.ready (always ready)
//
// One sample per cycle sustained while out_ch accepts results; a stall holds the flow.
// The sample register feeds the classifier, whose state and the result register load together.
// A stalled result holds the result register; the sample register keeps taking a request
// while it is empty or while its content can move on.
// rst is synchronous: all thresholds return to their reset values and the boot window rearms.
module button_debounce_press_classifier
  import bdpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bdpc_in_if.sink     in_ch,
  bdpc_out_if.source  out_ch,
  bdpc_cfg_if.sink    cfg
);

  bdpc_cfg_t    cfg_regs;
  logic         s1_valid;
  bdpc_sample_t s1_sample;
  logic         out_valid;
  press_event_t out_event;
  press_event_t core_event;
  logic         s2_open;
  logic         advance;

  assign s2_open = !out_valid || out_ch.ready;
  assign advance = s1_valid && s2_open;
  assign in_ch.ready = !s1_valid || s2_open;
  assign out_ch.valid = out_valid;
  assign out_ch.press_event = out_event;

  bdpc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_regs (cfg_regs)
  );

  bdpc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_regs    (cfg_regs),
    .advance     (advance),
    .sample      (s1_sample),
    .press_event (core_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample.pin_level <= in_ch.pin_level;
      s1_sample.now_ms <= in_ch.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= core_event;
    end
  end

endmodule

// ===== design/bdpc_checker.sv =====
// Port-level checker for the button press classifier, bound to the top level.
module bdpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] press_event
);

  logic [1:0] in_flight;
  logic [1:0] in_flight_next;
  logic       in_acc;
  logic       out_acc;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    in_flight_next = in_flight + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight_next;
    end
  end

  // no result without an outstanding request
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (in_flight != 2'd0))
    else $error("result delivered with no request outstanding");

  // two register stages bound the requests in flight
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 2'd2)
    else $error("more requests in flight than stages");

  // an empty block never refuses a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (in_flight == 2'd0) |-> in_ready)
    else $error("input refused while empty");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(press_event)))
    else $error("stalled result changed or dropped");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .press_event (out_ch.press_event)
);

// ===== test/button_debounce_press_classifier_tb.sv =====
// Self-checking testbench for the button debounce and press classifier.
module button_debounce_press_classifier_tb;
  import bdpc_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst;

  bdpc_in_if  in_ch ();
  bdpc_out_if out_ch ();
  bdpc_cfg_if cfg_ch ();

  button_debounce_press_classifier dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // classifier copy: thresholds and press tracking state
  bdpc_cfg_t thr;
  logic      settled_level;
  logic      raw_level;
  time_t     change_ms;
  time_t     press_ms;
  time_t     window_base;
  logic      reported;
  logic      boot_hold;
  logic      window_open;

  press_event_t expected_events[$];
  int           events_seen[4];
  int           samples_taken = 0;
  int           settings_applied = 0;
  int           mismatches = 0;

  time_t clock_ms = '0;
  logic  steady = 1'b0;
  int    hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_classifier();
    thr.debounce_time      = DEBOUNCE_TIME_RESET;
    thr.long_press_time    = LONG_PRESS_TIME_RESET;
    thr.boot_window_time   = BOOT_WINDOW_TIME_RESET;
    thr.recovery_hold_time = RECOVERY_HOLD_TIME_RESET;
    settled_level = LEVEL_RELEASED;
    raw_level     = LEVEL_RELEASED;
    change_ms     = '0;
    press_ms      = '0;
    window_base   = '0;
    reported      = 1'b0;
    boot_hold     = 1'b0;
    window_open   = 1'b0;
  endfunction

  function automatic void apply_threshold(input cfg_index_t idx, input time_t value);
    case (idx)
      REG_DEBOUNCE_TIME:      thr.debounce_time = value;
      REG_LONG_PRESS_TIME:    thr.long_press_time = value;
      REG_BOOT_WINDOW_TIME:   thr.boot_window_time = value;
      REG_RECOVERY_HOLD_TIME: thr.recovery_hold_time = value;
      default: ;
    endcase
  endfunction

  // Debounce one sample and classify the press it belongs to.
  function automatic press_event_t classify_sample(input logic level, input time_t stamp);
    time_t since_change;
    time_t since_boot;
    time_t held;
    if (!window_open) begin
      window_base = stamp;
      window_open = 1'b1;
    end
    if (level != raw_level) begin
      raw_level = level;
      change_ms = stamp;
    end
    since_change = stamp - change_ms;
    if (since_change >= thr.debounce_time && level != settled_level) begin
      settled_level = level;
      if (level == LEVEL_PRESSED) begin
        press_ms   = stamp;
        reported   = 1'b0;
        since_boot = stamp - window_base;
        boot_hold  = since_boot <= thr.boot_window_time;
      end else if (!reported) begin
        held = stamp - press_ms;
        if (boot_hold && held >= thr.long_press_time) begin
          reported = 1'b1;
          return EV_LONG;
        end
        return EV_SHORT;
      end
    end
    held = stamp - press_ms;
    if (settled_level == LEVEL_PRESSED && !reported && held >= thr.long_press_time) begin
      if (!boot_hold) begin
        reported = 1'b1;
        return EV_LONG;
      end
      if (held >= thr.recovery_hold_time) begin
        reported = 1'b1;
        return EV_RECOVERY;
      end
    end
    return EV_NONE;
  endfunction

  // Track accepted requests on all three channels.
  always @(posedge clk) begin : scoreboard
    press_event_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_threshold(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        expected_events.push_back(classify_sample(in_ch.pin_level, in_ch.now_ms));
        samples_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          note_failure($sformatf("press_event %0d arrived with nothing expected",
                                 out_ch.press_event));
        end else begin
          want = expected_events.pop_front();
          if (out_ch.press_event !== want)
            note_failure($sformatf("press_event expected %s (%0d) got %0d",
                                   want.name(), want, out_ch.press_event));
          else
            events_seen[want]++;
        end
      end
    end
  end

  // Result sink: random stalls, or a long hold when asked for one.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = idle_cycles();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic level, input time_t stamp);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= level;
    in_ch.now_ms    <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop the request line and wait for every outstanding result.
  task automatic settle_pipeline();
    in_ch.valid <= 1'b0;
    // let the scoreboard log the last accepted request first
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input time_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_thresholds(input time_t bounce_ms, input time_t long_ms,
                                    input time_t window_ms, input time_t recovery_ms);
    write_reg(REG_DEBOUNCE_TIME, bounce_ms);
    write_reg(REG_LONG_PRESS_TIME, long_ms);
    write_reg(REG_BOOT_WINDOW_TIME, window_ms);
    write_reg(REG_RECOVERY_HOLD_TIME, recovery_ms);
    // a stray index last, so a wrongly decoded write would clobber a real one
    write_reg(cfg_index_t'($urandom_range(4, 255)), time_t'($urandom));
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  // Chatter around the target level, then hold it past the debounce time.
  task automatic bounce_to(input logic level, input int bounce_ms);
    int toggles;
    toggles = $urandom_range(0, 3);
    for (int k = toggles; k >= 0; k--) begin
      clock_ms += time_t'($urandom_range(0, bounce_ms));
      send_sample((k % 2 == 0) ? level : ~level, clock_ms);
    end
    clock_ms += time_t'(bounce_ms + $urandom_range(0, 20));
    send_sample(level, clock_ms);
  endtask

  task automatic press_cycle();
    int bounce_ms;
    int long_ms;
    int recovery_ms;
    int hold_ms;
    int samples;
    int step_ms;
    bounce_ms   = int'(thr.debounce_time);
    long_ms     = int'(thr.long_press_time);
    recovery_ms = int'(thr.recovery_hold_time);
    clock_ms += time_t'($urandom_range(1, 2000));
    send_sample(LEVEL_RELEASED, clock_ms);
    bounce_to(LEVEL_PRESSED, bounce_ms);
    case ($urandom_range(0, 3))
      0: hold_ms = $urandom_range(0, long_ms + 1);
      1: hold_ms = long_ms + $urandom_range(0, 10) - 5;
      2: hold_ms = recovery_ms + $urandom_range(0, 10) - 5;
      default: hold_ms = $urandom_range(0, recovery_ms + long_ms + 2000);
    endcase
    if (hold_ms < 0) hold_ms = 0;
    samples = $urandom_range(1, 8);
    step_ms = hold_ms / samples;
    repeat (samples) begin
      clock_ms += time_t'(step_ms + $urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) begin
        // brief glitch towards released while held
        send_sample(LEVEL_RELEASED, clock_ms);
        clock_ms += time_t'($urandom_range(0, bounce_ms));
      end
      send_sample(LEVEL_PRESSED, clock_ms);
    end
    bounce_to(LEVEL_RELEASED, bounce_ms);
  endtask

  // Reset thresholds: boot press to recovery, short and long presses, timestamp wrap.
  task automatic test_reset_thresholds();
    send_sample(LEVEL_RELEASED, 32'hFFFF_FFF0);
    send_sample(LEVEL_PRESSED, 32'hFFFF_FFF8);
    send_sample(LEVEL_RELEASED, 32'hFFFF_FFFC);
    send_sample(LEVEL_PRESSED, 32'hFFFF_FFFF);
    send_sample(LEVEL_PRESSED, 32'h0000_0030);
    send_sample(LEVEL_PRESSED, 32'h0000_0030 + 1300);
    send_sample(LEVEL_PRESSED, 32'h0000_0030 + 10000);
    send_sample(LEVEL_RELEASED, 32'h0000_0030 + 10050);
    send_sample(LEVEL_RELEASED, 32'h0000_0030 + 10100);
    send_sample(LEVEL_PRESSED, 40000);
    send_sample(LEVEL_PRESSED, 40035);
    send_sample(LEVEL_RELEASED, 40100);
    send_sample(LEVEL_RELEASED, 40134);
    send_sample(LEVEL_RELEASED, 40135);
    send_sample(LEVEL_PRESSED, 50000);
    send_sample(LEVEL_PRESSED, 50040);
    send_sample(LEVEL_PRESSED, 51240);
    send_sample(LEVEL_PRESSED, 32'h7FFF_FFFF);
    send_sample(LEVEL_PRESSED, 32'hFFFF_FFFF);
    send_sample(LEVEL_RELEASED, 32'h0000_0000);
    send_sample(LEVEL_RELEASED, 32'h0000_0100);
  endtask

  // Zero and all-ones thresholds.
  task automatic test_threshold_extremes();
    settle_pipeline();
    program_thresholds('0, '0, '1, '0);
    clock_ms = 32'h0001_0000;
    send_sample(LEVEL_PRESSED, clock_ms);
    send_sample(LEVEL_RELEASED, clock_ms + 1);
    settle_pipeline();
    program_thresholds('0, time_t'(100), '1, '1);
    send_sample(LEVEL_PRESSED, clock_ms + 10);
    send_sample(LEVEL_PRESSED, clock_ms + 160);
    send_sample(LEVEL_RELEASED, clock_ms + 170);
    send_sample(LEVEL_PRESSED, clock_ms + 200);
    send_sample(LEVEL_RELEASED, clock_ms + 250);
    settle_pipeline();
    program_thresholds('1, '1, '0, '1);
    send_sample(LEVEL_PRESSED, clock_ms + 300);
    send_sample(LEVEL_PRESSED, clock_ms + 299);
    send_sample(LEVEL_RELEASED, clock_ms + 400);
    send_sample(LEVEL_RELEASED, clock_ms + 399);
  endtask

  task automatic test_press_sequences(input int budget);
    int    stop_at;
    int    phase_end;
    int    phase;
    time_t bounce_ms;
    time_t long_ms;
    time_t window_ms;
    time_t recovery_ms;
    stop_at = samples_taken + budget;
    phase = 0;
    while (samples_taken < stop_at) begin
      settle_pipeline();
      case ($urandom_range(0, 4))
        0:       bounce_ms = '0;
        1, 2:    bounce_ms = time_t'($urandom_range(1, 60));
        default: bounce_ms = time_t'($urandom_range(61, 500));
      endcase
      long_ms = ($urandom_range(0, 9) == 0) ? '0 : time_t'($urandom_range(100, 3000));
      case ($urandom_range(0, 2))
        0:       window_ms = '1;
        1:       window_ms = '0;
        default: window_ms = time_t'($urandom);
      endcase
      recovery_ms = ($urandom_range(0, 4) == 0) ? '0 : time_t'($urandom_range(500, 20000));
      program_thresholds(bounce_ms, long_ms, window_ms, recovery_ms);
      if ($urandom_range(0, 3) == 0) clock_ms = time_t'($urandom);
      steady = (phase % 3 == 2);
      phase_end = samples_taken + 180;
      while (samples_taken < phase_end) press_cycle();
      phase++;
    end
    steady = 1'b0;
  endtask

  // Random levels with scattered or jumping timestamps.
  task automatic test_line_noise();
    settle_pipeline();
    program_thresholds(time_t'($urandom_range(0, 40)), time_t'($urandom_range(0, 1500)),
                       time_t'($urandom), time_t'($urandom_range(0, 12000)));
    repeat (150) begin
      if ($urandom_range(0, 1) == 1) clock_ms = time_t'($urandom);
      else clock_ms += time_t'($urandom_range(0, 80));
      send_sample(logic'($urandom_range(0, 1)), clock_ms);
    end
  endtask

  // Hold the result side off while requests keep coming, so the input stalls.
  task automatic test_output_stall();
    settle_pipeline();
    steady = 1'b1;
    hold_request = 200;
    repeat (4) press_cycle();
    steady = 1'b0;
  endtask

  initial begin
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.pin_level <= LEVEL_RELEASED;
    in_ch.now_ms    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_DEBOUNCE_TIME;
    cfg_ch.data     <= '0;
    reset_classifier();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_thresholds();
    test_threshold_extremes();
    test_press_sequences(1300);
    test_line_noise();
    test_output_stall();
    settle_pipeline();

    if (expected_events.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_events.size()));
    $display("covered %0d samples under %0d threshold settings plus reset values",
             samples_taken, settings_applied);
    $display("results: %0d none, %0d short, %0d long, %0d recovery; %0d mismatches",
             events_seen[EV_NONE], events_seen[EV_SHORT], events_seen[EV_LONG],
             events_seen[EV_RECOVERY], mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
